// ===== rtl/swc_pkg.sv =====
// Shared types, widths and helpers for the sphere workspace clamp.
package swc_pkg;

  localparam int POS_W       = 24;               // position field width
  localparam int GAIN_W      = 10;
  localparam int RAD_W       = POS_W - 1;
  localparam int PROD_W      = POS_W + GAIN_W + 1; // delta * gain
  localparam int D_W         = PROD_W - 8;        // signed offset from center
  localparam int MAG_W       = POS_W + 2;         // |offset|
  localparam int DS_W        = 2 * MAG_W + 2;     // squared distance
  localparam int ROOT_W      = DS_W / 2;          // floor sqrt of distance
  localparam int NUM_W       = MAG_W + RAD_W;     // |offset| * radius
  localparam int CFG_IDX_W   = 3;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [RAD_W-1:0]  RADIUS_RESET = RAD_W'(580000);
  localparam logic [GAIN_W-1:0] GAIN_RESET   = GAIN_W'(384);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER_X = 3'd0,
    CFG_CENTER_Y = 3'd1,
    CFG_CENTER_Z = 3'd2,
    CFG_RADIUS   = 3'd3,
    CFG_GAIN     = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic signed [POS_W-1:0] center_x;
    logic signed [POS_W-1:0] center_y;
    logic signed [POS_W-1:0] center_z;
    logic [RAD_W-1:0]        radius;
    logic [GAIN_W-1:0]       gain;
  } cfg_t;

  typedef struct packed {
    logic signed [POS_W-1:0] cur_x;
    logic signed [POS_W-1:0] cur_y;
    logic signed [POS_W-1:0] cur_z;
    logic signed [POS_W-1:0] delta_x;
    logic signed [POS_W-1:0] delta_y;
    logic signed [POS_W-1:0] delta_z;
  } req_t;

  typedef struct packed {
    logic signed [POS_W-1:0] out_x;
    logic signed [POS_W-1:0] out_y;
    logic signed [POS_W-1:0] out_z;
    logic                    was_clamped;
  } rsp_t;

  // classified item handed from front to back
  typedef struct packed {
    logic signed [D_W-1:0] d_x;
    logic signed [D_W-1:0] d_y;
    logic signed [D_W-1:0] d_z;
    logic [DS_W-1:0]       dist_sq;
    logic                  clamp;
  } work_t;

  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [D_W:0] v);
    logic signed [D_W:0] hi;
    logic signed [D_W:0] lo;
    hi = {{(D_W - POS_W + 2){1'b0}}, {(POS_W - 1){1'b1}}};
    lo = ~hi;
    if (v > hi) begin
      return hi[POS_W-1:0];
    end else if (v < lo) begin
      return lo[POS_W-1:0];
    end
    return v[POS_W-1:0];
  endfunction

endpackage

// ===== rtl/sphere_workspace_clamp_core.sv =====
// Top level of the sphere workspace clamp: config registers, front, queue, back.
// Keeps a commanded arm position inside a ball. Each request item carries the
// current position and a commanded delta; the target is cur + floor(delta *
// gain / 256). If the target lies farther from the center than the radius,
// each offset is scaled by radius / floor(sqrt(dist^2)), truncated toward
// zero, and was_clamped is set. Results are center + offset, saturated to the
// 24-bit signed range. Unless the output stalls, one item is accepted per
// clock and one result leaves per clock; results come out in order. The path
// is 4 front stages, the queue, a root load stage plus 27 square-root stages
// (one root bit per stage), one multiply stage, 26 divide stages (one
// quotient bit per stage, three axes in parallel) and the output register.
// A stalled output fills the 4-entry queue before req_ready drops. Config is
// written through cfg_we/cfg_idx/cfg_data with no wait; writes only while no
// item is in flight.
module sphere_workspace_clamp_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [swc_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [swc_pkg::POS_W-1:0]    cfg_data,
  input  logic                         req_valid,
  output logic                         req_ready,
  input  swc_pkg::req_t                req,
  output logic                         rsp_valid,
  input  logic                         rsp_ready,
  output swc_pkg::rsp_t                rsp
);
  import swc_pkg::*;

  cfg_t  cfg;
  logic  push_valid, push_ready;
  work_t push_data;
  logic  pop_valid, pop_ready;
  work_t pop_data;

  // register file; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.center_x <= '0;
      cfg.center_y <= '0;
      cfg.center_z <= '0;
      cfg.radius   <= RADIUS_RESET;
      cfg.gain     <= GAIN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_idx))
        CFG_CENTER_X: cfg.center_x <= cfg_data;
        CFG_CENTER_Y: cfg.center_y <= cfg_data;
        CFG_CENTER_Z: cfg.center_z <= cfg_data;
        CFG_RADIUS:   cfg.radius   <= cfg_data[RAD_W-1:0];
        CFG_GAIN:     cfg.gain     <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // front: gain, offset, squared distance, sphere test
  swc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req        (req),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // decouples the front from back-pressure on the result side
  swc_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // back: root, projection divide, output
  swc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

// ===== rtl/swc_front.sv =====
// Front end: gain scaling, offsets, squared distance and sphere test.
module swc_front (
  input  logic          clk,
  input  logic          rst,
  input  swc_pkg::cfg_t cfg,
  input  logic          req_valid,
  output logic          req_ready,
  input  swc_pkg::req_t req,
  output logic          push_valid,
  input  logic          push_ready,
  output swc_pkg::work_t push_data
);
  import swc_pkg::*;

  logic                     en;
  logic signed [POS_W-1:0]  cur_in [3];
  logic signed [POS_W-1:0]  del_in [3];
  logic signed [POS_W-1:0]  cen [3];
  logic signed [GAIN_W:0]   gain_s;

  logic                     s1_valid, s2_valid, s3_valid, s4_valid;
  logic signed [POS_W-1:0]  s1_cur [3];
  logic signed [PROD_W-1:0] s1_prod [3];
  logic signed [D_W-1:0]    s2_d [3];
  logic signed [D_W-1:0]    s3_d [3];
  logic [2*MAG_W-1:0]       s3_sq [3];
  logic signed [D_W-1:0]    s4_d [3];
  logic [DS_W-1:0]          s4_dist;
  logic                     s4_clamp;
  logic [2*RAD_W-1:0]       rsq;
  logic [MAG_W-1:0]         mag [3];
  logic [DS_W-1:0]          dist_sum;

  assign cur_in[0] = req.cur_x;
  assign cur_in[1] = req.cur_y;
  assign cur_in[2] = req.cur_z;
  assign del_in[0] = req.delta_x;
  assign del_in[1] = req.delta_y;
  assign del_in[2] = req.delta_z;
  assign cen[0]    = cfg.center_x;
  assign cen[1]    = cfg.center_y;
  assign cen[2]    = cfg.center_z;
  assign gain_s    = $signed({1'b0, cfg.gain});

  assign en        = !s4_valid || push_ready;
  assign req_ready = en;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      mag[a] = s2_d[a][D_W-1] ? MAG_W'(-s2_d[a]) : MAG_W'(s2_d[a]);
    end
    dist_sum = DS_W'(s3_sq[0]) + DS_W'(s3_sq[1]) + DS_W'(s3_sq[2]);
  end

  always_ff @(posedge clk) begin
    rsq <= (2*RAD_W)'(cfg.radius) * (2*RAD_W)'(cfg.radius);
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= req_valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
    end
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        s1_cur[a]  <= cur_in[a];
        s1_prod[a] <= PROD_W'(del_in[a]) * PROD_W'(gain_s);
        // floor(delta*gain/256) via arithmetic shift
        s2_d[a]    <= D_W'(s1_cur[a]) + D_W'(s1_prod[a] >>> 8) - D_W'(cen[a]);
        s3_d[a]    <= s2_d[a];
        s3_sq[a]   <= (2*MAG_W)'(mag[a]) * (2*MAG_W)'(mag[a]);
        s4_d[a]    <= s3_d[a];
      end
      s4_dist  <= dist_sum;
      s4_clamp <= dist_sum > DS_W'(rsq);
    end
  end

  assign push_valid        = s4_valid;
  assign push_data.d_x     = s4_d[0];
  assign push_data.d_y     = s4_d[1];
  assign push_data.d_z     = s4_d[2];
  assign push_data.dist_sq = s4_dist;
  assign push_data.clamp   = s4_clamp;

endmodule

// ===== rtl/swc_fifo.sv =====
// Small item queue between front and back.
module swc_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  swc_pkg::work_t push_data,
  output logic           pop_valid,
  input  logic           pop_ready,
  output swc_pkg::work_t pop_data
);
  import swc_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  work_t            mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push, pop;

  assign push_ready = count != CNT_W'(QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count above depth");
  a_count_up: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + 1'b1)
    else $error("queue count missed a push");
  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    count != CNT_W'(QUEUE_DEPTH) && count != '0 |-> wr_ptr != rd_ptr)
    else $error("queue pointers out of step with count");
`endif

endmodule

// ===== rtl/swc_back.sv =====
// Back end: pipelined square root, projection divide, re-centering, saturation.
module swc_back (
  input  logic           clk,
  input  logic           rst,
  input  swc_pkg::cfg_t  cfg,
  input  logic           pop_valid,
  output logic           pop_ready,
  input  swc_pkg::work_t pop_data,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output swc_pkg::rsp_t  rsp
);
  import swc_pkg::*;

  localparam int RM_W = ROOT_W + 1;

  logic                    en;
  logic signed [POS_W-1:0] cen [3];

  // square root stages
  logic                  sq_valid [ROOT_W+1];
  logic [DS_W-1:0]       sq_n     [ROOT_W+1];
  logic [RM_W-1:0]       sq_rem   [ROOT_W+1];
  logic [ROOT_W-1:0]     sq_root  [ROOT_W+1];
  logic signed [D_W-1:0] sq_d     [ROOT_W+1][3];
  logic                  sq_clamp [ROOT_W+1];

  // divide stages; lo holds remaining dividend bits, then quotient bits
  logic                  dv_valid [MAG_W+1];
  logic [ROOT_W-1:0]     dv_rem   [MAG_W+1][3];
  logic [MAG_W-1:0]      dv_lo    [MAG_W+1][3];
  logic [ROOT_W-1:0]     dv_den   [MAG_W+1];
  logic signed [D_W-1:0] dv_d     [MAG_W+1][3];
  logic                  dv_clamp [MAG_W+1];

  logic [NUM_W-1:0]      num [3];
  logic [MAG_W-1:0]      mag [3];
  logic signed [D_W:0]   fin [3];

  assign cen[0]    = cfg.center_x;
  assign cen[1]    = cfg.center_y;
  assign cen[2]    = cfg.center_z;
  assign en        = !rsp_valid || rsp_ready;
  assign pop_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_valid[0] <= 1'b0;
    end else if (en) begin
      sq_valid[0] <= pop_valid;
    end
    if (en) begin
      sq_n[0]     <= pop_data.dist_sq;
      sq_rem[0]   <= '0;
      sq_root[0]  <= '0;
      sq_d[0][0]  <= pop_data.d_x;
      sq_d[0][1]  <= pop_data.d_y;
      sq_d[0][2]  <= pop_data.d_z;
      sq_clamp[0] <= pop_data.clamp;
    end
  end

  for (genvar k = 1; k <= ROOT_W; k++) begin : g_sqrt
    logic [RM_W+1:0] rem_sh;
    logic [RM_W+1:0] trial;
    logic            ge;

    always_comb begin
      rem_sh = {sq_rem[k-1], sq_n[k-1][DS_W-1 -: 2]};
      trial  = (RM_W+2)'({sq_root[k-1], 2'b01});
      ge     = rem_sh >= trial;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_valid[k] <= 1'b0;
      end else if (en) begin
        sq_valid[k] <= sq_valid[k-1];
      end
      if (en) begin
        sq_n[k]     <= sq_n[k-1] << 2;
        sq_rem[k]   <= ge ? RM_W'(rem_sh - trial) : RM_W'(rem_sh);
        sq_root[k]  <= {sq_root[k-1][ROOT_W-2:0], ge};
        sq_d[k]     <= sq_d[k-1];
        sq_clamp[k] <= sq_clamp[k-1];
      end
    end
  end

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      mag[a] = sq_d[ROOT_W][a][D_W-1] ? MAG_W'(-sq_d[ROOT_W][a]) : MAG_W'(sq_d[ROOT_W][a]);
    end
  end

  // product stage: |d| * radius, split into starting remainder and low bits
  always_ff @(posedge clk) begin
    if (rst) begin
      dv_valid[0] <= 1'b0;
    end else if (en) begin
      dv_valid[0] <= sq_valid[ROOT_W];
    end
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        num[a] <= NUM_W'(mag[a]) * NUM_W'(cfg.radius);
      end
      dv_den[0]   <= sq_root[ROOT_W];
      dv_d[0]     <= sq_d[ROOT_W];
      dv_clamp[0] <= sq_clamp[ROOT_W];
    end
  end

  for (genvar a = 0; a < 3; a++) begin : g_split
    assign dv_rem[0][a] = ROOT_W'(num[a][NUM_W-1:MAG_W]);
    assign dv_lo[0][a]  = num[a][MAG_W-1:0];
  end

  for (genvar j = 1; j <= MAG_W; j++) begin : g_div
    logic [ROOT_W:0] rem_sh [3];
    logic            ge     [3];

    always_comb begin
      for (int a = 0; a < 3; a++) begin
        rem_sh[a] = {dv_rem[j-1][a], dv_lo[j-1][a][MAG_W-1]};
        ge[a]     = rem_sh[a] >= (ROOT_W+1)'(dv_den[j-1]);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_valid[j] <= 1'b0;
      end else if (en) begin
        dv_valid[j] <= dv_valid[j-1];
      end
      if (en) begin
        for (int a = 0; a < 3; a++) begin
          dv_rem[j][a] <= ge[a] ? ROOT_W'(rem_sh[a] - (ROOT_W+1)'(dv_den[j-1]))
                                : ROOT_W'(rem_sh[a]);
          dv_lo[j][a]  <= {dv_lo[j-1][a][MAG_W-2:0], ge[a]};
        end
        dv_den[j]   <= dv_den[j-1];
        dv_d[j]     <= dv_d[j-1];
        dv_clamp[j] <= dv_clamp[j-1];
      end
    end
  end

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      logic signed [D_W:0] qs;
      logic signed [D_W:0] off;
      qs = (D_W+1)'($signed({1'b0, dv_lo[MAG_W][a]}));
      if (dv_clamp[MAG_W]) begin
        off = dv_d[MAG_W][a][D_W-1] ? -qs : qs;
      end else begin
        off = (D_W+1)'(dv_d[MAG_W][a]);
      end
      fin[a] = (D_W+1)'(cen[a]) + off;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (en) begin
      rsp_valid <= dv_valid[MAG_W];
    end
    if (en) begin
      rsp.out_x       <= sat_pos(fin[0]);
      rsp.out_y       <= sat_pos(fin[1]);
      rsp.out_z       <= sat_pos(fin[2]);
      rsp.was_clamped <= dv_clamp[MAG_W];
    end
  end

endmodule
